[rtl/core/lsmd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsmd_pkg
// Shared constants, types and the sector classifier for the lidar sector
// minimum distance block.
// ----------------------------------------------------------------------------
package lsmd_pkg;

  localparam int POINTS_PER_PACKET = 12;
  localparam int ANG_UNIT          = 100 * POINTS_PER_PACKET;  // units per degree
  localparam int FULL_TURN         = 360 * ANG_UNIT;
  localparam int ANGLE_W           = ($clog2(FULL_TURN) > 19) ? $clog2(FULL_TURN) : 19;

  localparam int ACC_W        = 32;
  localparam int DATA_W       = 16;
  localparam int MPL_W        = 16;
  localparam int IDX_W        = 4;
  localparam int DIST_W       = 15;
  localparam int SECTOR_W     = 3;
  localparam int OUT_ANGLE_W  = 19;

  localparam logic [ACC_W-1:0] SPAN_MOD_ACC   = ACC_W'(36000);
  // residue of 2**64 modulo 36000, used when end + 36000 - start wraps below zero
  localparam logic [ACC_W-1:0] WRAP_RESIDUE   = ACC_W'(3616);
  localparam logic [ACC_W-1:0] FULL_TURN_ACC  = ACC_W'(FULL_TURN);
  localparam logic [ACC_W-1:0] POINTS_ACC     = ACC_W'(POINTS_PER_PACKET);
  localparam logic [MPL_W-1:0] POINTS_MPL     = MPL_W'(POINTS_PER_PACKET);
  localparam logic [MPL_W-1:0] ANG_UNIT_MPL   = MPL_W'(ANG_UNIT);

  localparam logic [DIST_W-1:0] CLEAR_VALUE   = DIST_W'(32000);
  localparam logic [DATA_W-1:0] RATE_RESET    = DATA_W'(4500);

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [SECTOR_W-1:0] SEC_0     = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_1     = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_2     = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_3     = 3'd3;
  localparam logic [SECTOR_W-1:0] NO_SECTOR = 3'd4;

  localparam logic [ANGLE_W-1:0] B30  = ANGLE_W'(30 * ANG_UNIT);
  localparam logic [ANGLE_W-1:0] B60  = ANGLE_W'(60 * ANG_UNIT);
  localparam logic [ANGLE_W-1:0] B120 = ANGLE_W'(120 * ANG_UNIT);
  localparam logic [ANGLE_W-1:0] B150 = ANGLE_W'(150 * ANG_UNIT);
  localparam logic [ANGLE_W-1:0] B210 = ANGLE_W'(210 * ANG_UNIT);
  localparam logic [ANGLE_W-1:0] B240 = ANGLE_W'(240 * ANG_UNIT);
  localparam logic [ANGLE_W-1:0] B300 = ANGLE_W'(300 * ANG_UNIT);
  localparam logic [ANGLE_W-1:0] B330 = ANGLE_W'(330 * ANG_UNIT);

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SPAN_BASE,
    ST_SPAN_SUB,
    ST_SPAN_WRAP,
    ST_SPAN_FIX,
    ST_SPEED,
    ST_MUL_LIM,
    ST_MUL_PROD,
    ST_CMP,
    ST_MUL_BASE,
    ST_MUL_OFS,
    ST_ANG_FIX,
    ST_CLASS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                valid;
    logic [ANGLE_W-1:0]  angle;
    logic [SECTOR_W-1:0] sector;
    logic [DATA_W-1:0]   range_mm;
  } result_t;

  // Strict bounds: angles exactly on a sector edge belong to no sector.
  function automatic logic [SECTOR_W-1:0] classify(input logic [ANGLE_W-1:0] a);
    logic [SECTOR_W-1:0] s;
    s = NO_SECTOR;
    if (a < B30 || a > B330) begin
      s = SEC_0;
    end else if (a > B60 && a < B120) begin
      s = SEC_1;
    end else if (a > B150 && a < B210) begin
      s = SEC_2;
    end else if (a > B240 && a < B300) begin
      s = SEC_3;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[rtl/core/lidar_sector_min_distance.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_sector_min_distance
// Interpolates a lidar point angle, checks packet plausibility and keeps
// the minimum distance of four 60-degree sectors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one point or a clear command per
//   transaction. Output channel (out_valid/out_ready) returns one result per
//   input: point_valid, point_angle, sector and the four sector minima after
//   the item. cfg_valid/cfg_ready writes measure_rate; cfg_ready is always
//   high, write only while no item is in flight.
//   How long an item takes depends on its path: a clear command or a point
//   rejected on speed, index or zero range goes from the check straight to
//   the result; a point over the span limit stops after the compare; a full
//   point runs the shift-add multiplies (plausibility limit, span times rate,
//   angle) and the modulo steps, all on one shared 32-bit adder.
//   One item is in work at a time; in_ready is high only when the sequencer
//   is idle.
//   The result sits in an output register, so the next item is accepted
//   while the receiver stalls; the sequencer then holds its finished result
//   until the output register frees up.
//   Reset: measure_rate returns to 4500, all sector minima to 32000, both
//   channels go empty.
// ----------------------------------------------------------------------------
module lidar_sector_min_distance (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                command,
  input  wire logic [lsmd_pkg::DATA_W-1:0]         packet_start,
  input  wire logic [lsmd_pkg::DATA_W-1:0]         packet_end,
  input  wire logic [lsmd_pkg::DATA_W-1:0]         rotation_speed,
  input  wire logic [lsmd_pkg::IDX_W-1:0]          point_index,
  input  wire logic [lsmd_pkg::DATA_W-1:0]         range_mm,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     point_valid,
  output logic      [lsmd_pkg::OUT_ANGLE_W-1:0]    point_angle,
  output logic      [lsmd_pkg::SECTOR_W-1:0]       sector,
  output logic      [lsmd_pkg::DIST_W-1:0]         nearest_sector_0,
  output logic      [lsmd_pkg::DIST_W-1:0]         nearest_sector_1,
  output logic      [lsmd_pkg::DIST_W-1:0]         nearest_sector_2,
  output logic      [lsmd_pkg::DIST_W-1:0]         nearest_sector_3,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lsmd_pkg::DATA_W-1:0]         cfg_data
);

  logic [lsmd_pkg::DATA_W-1:0] measure_rate;
  logic                        res_valid;
  logic                        res_take;
  lsmd_pkg::result_t           res;
  logic [lsmd_pkg::DIST_W-1:0] min_store [4];
  logic [lsmd_pkg::DIST_W-1:0] min_store_next [4];

  lsmd_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .packet_start   (packet_start),
    .packet_end     (packet_end),
    .rotation_speed (rotation_speed),
    .point_index    (point_index),
    .range_mm       (range_mm),
    .measure_rate   (measure_rate),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res)
  );

  assign cfg_ready = 1'b1;
  assign res_take  = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_rate <= lsmd_pkg::RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      measure_rate <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      min_store_next[k] = min_store[k];
    end
    if (res.clear) begin
      for (int k = 0; k < 4; k++) begin
        min_store_next[k] = lsmd_pkg::CLEAR_VALUE;
      end
    end else if (res.valid && res.sector != lsmd_pkg::NO_SECTOR &&
                 {1'b0, min_store[res.sector[1:0]]} > res.range_mm) begin
      min_store_next[res.sector[1:0]] = res.range_mm[lsmd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        min_store[k] <= lsmd_pkg::CLEAR_VALUE;
      end
    end else if (res_take) begin
      for (int k = 0; k < 4; k++) begin
        min_store[k] <= min_store_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      point_valid      <= res.valid;
      point_angle      <= res.angle[lsmd_pkg::OUT_ANGLE_W-1:0];
      sector           <= res.sector;
      nearest_sector_0 <= min_store_next[0];
      nearest_sector_1 <= min_store_next[1];
      nearest_sector_2 <= min_store_next[2];
      nearest_sector_3 <= min_store_next[3];
    end
  end

  a_clear_minima: assert property (@(posedge clk) disable iff (rst)
    (res_take && res.clear) |=>
      (nearest_sector_0 == lsmd_pkg::CLEAR_VALUE && nearest_sector_1 == lsmd_pkg::CLEAR_VALUE &&
       nearest_sector_2 == lsmd_pkg::CLEAR_VALUE && nearest_sector_3 == lsmd_pkg::CLEAR_VALUE))
    else $error("clear transaction left a sector minimum set");

  a_minima_bounded: assert property (@(posedge clk) disable iff (rst)
    res_take |=> (min_store[0] <= lsmd_pkg::CLEAR_VALUE && min_store[1] <= lsmd_pkg::CLEAR_VALUE &&
                  min_store[2] <= lsmd_pkg::CLEAR_VALUE && min_store[3] <= lsmd_pkg::CLEAR_VALUE))
    else $error("sector minimum above clear value");

endmodule
`default_nettype wire

[rtl/core/lsmd_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsmd_alu
// Shared adder/subtractor; carry out doubles as borrow on subtract.
// ----------------------------------------------------------------------------
module lsmd_alu (
  input  wire logic [lsmd_pkg::ACC_W-1:0] a,
  input  wire logic [lsmd_pkg::ACC_W-1:0] b,
  input  wire lsmd_pkg::alu_op_t          op,
  output logic      [lsmd_pkg::ACC_W-1:0] y,
  output logic                            cout
);

  logic [lsmd_pkg::ACC_W:0] full;

  always_comb begin
    unique case (op)
      lsmd_pkg::OP_SUB: full = {1'b0, a} - {1'b0, b};
      lsmd_pkg::OP_ADD: full = {1'b0, a} + {1'b0, b};
      default:          full = {1'b0, a} + {1'b0, b};
    endcase
  end

  assign y    = full[lsmd_pkg::ACC_W-1:0];
  assign cout = full[lsmd_pkg::ACC_W];

endmodule
`default_nettype wire

[rtl/core/lsmd_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lsmd_ctrl
// Sequencer and datapath registers: span reduction, plausibility limit
// (span * rate <= speed*1.5*units, equivalent to the truncating quotient
// test), angle interpolation and sector class, all on one shared ALU.
// ----------------------------------------------------------------------------
module lsmd_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             command,
  input  wire logic [lsmd_pkg::DATA_W-1:0]      packet_start,
  input  wire logic [lsmd_pkg::DATA_W-1:0]      packet_end,
  input  wire logic [lsmd_pkg::DATA_W-1:0]      rotation_speed,
  input  wire logic [lsmd_pkg::IDX_W-1:0]       point_index,
  input  wire logic [lsmd_pkg::DATA_W-1:0]      range_mm,
  input  wire logic [lsmd_pkg::DATA_W-1:0]      measure_rate,
  output logic                                  res_valid,
  input  wire logic                             res_take,
  output lsmd_pkg::result_t                     res
);

  lsmd_pkg::state_t state, state_next;

  logic                          cmd_q;
  logic [lsmd_pkg::DATA_W-1:0]   start_q;
  logic [lsmd_pkg::DATA_W-1:0]   end_q;
  logic [lsmd_pkg::DATA_W-1:0]   speed_q;
  logic [lsmd_pkg::IDX_W-1:0]    idx_q;
  logic [lsmd_pkg::DATA_W-1:0]   rng_q;
  logic [lsmd_pkg::ACC_W-1:0]    acc;
  logic [lsmd_pkg::ACC_W-1:0]    mcand;
  logic [lsmd_pkg::MPL_W-1:0]    mplier;
  logic [lsmd_pkg::DATA_W-1:0]   span;
  logic [lsmd_pkg::ACC_W-1:0]    lim;
  logic                          valid_q;
  logic [lsmd_pkg::SECTOR_W-1:0] sector_q;

  logic [lsmd_pkg::ACC_W-1:0]    alu_a;
  logic [lsmd_pkg::ACC_W-1:0]    alu_b;
  lsmd_pkg::alu_op_t             alu_op;
  logic [lsmd_pkg::ACC_W-1:0]    alu_y;
  logic                          alu_cout;
  logic                          early_reject;
  logic                          mul_done;

  lsmd_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .op   (alu_op),
    .y    (alu_y),
    .cout (alu_cout)
  );

  assign early_reject = (speed_q == '0) || (rng_q == '0) ||
                        ({{(lsmd_pkg::ACC_W-lsmd_pkg::IDX_W){1'b0}}, idx_q}
                         >= lsmd_pkg::POINTS_ACC);
  assign mul_done = (mplier == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lsmd_pkg::ST_IDLE: begin
        if (in_valid) state_next = lsmd_pkg::ST_CHECK;
      end
      lsmd_pkg::ST_CHECK: begin
        if (cmd_q == lsmd_pkg::CMD_CLEAR || early_reject) state_next = lsmd_pkg::ST_DONE;
        else state_next = lsmd_pkg::ST_SPAN_BASE;
      end
      lsmd_pkg::ST_SPAN_BASE: state_next = lsmd_pkg::ST_SPAN_SUB;
      lsmd_pkg::ST_SPAN_SUB: begin
        state_next = alu_cout ? lsmd_pkg::ST_SPAN_WRAP : lsmd_pkg::ST_SPAN_FIX;
      end
      lsmd_pkg::ST_SPAN_WRAP: state_next = lsmd_pkg::ST_SPAN_FIX;
      lsmd_pkg::ST_SPAN_FIX: begin
        if (!acc[lsmd_pkg::ACC_W-1] && alu_cout) state_next = lsmd_pkg::ST_SPEED;
      end
      lsmd_pkg::ST_SPEED: state_next = lsmd_pkg::ST_MUL_LIM;
      lsmd_pkg::ST_MUL_LIM: begin
        if (mul_done) state_next = lsmd_pkg::ST_MUL_PROD;
      end
      lsmd_pkg::ST_MUL_PROD: begin
        if (mul_done) state_next = lsmd_pkg::ST_CMP;
      end
      lsmd_pkg::ST_CMP: begin
        state_next = alu_cout ? lsmd_pkg::ST_DONE : lsmd_pkg::ST_MUL_BASE;
      end
      lsmd_pkg::ST_MUL_BASE: begin
        if (mul_done) state_next = lsmd_pkg::ST_MUL_OFS;
      end
      lsmd_pkg::ST_MUL_OFS: begin
        if (mul_done) state_next = lsmd_pkg::ST_ANG_FIX;
      end
      lsmd_pkg::ST_ANG_FIX: begin
        if (alu_cout) state_next = lsmd_pkg::ST_CLASS;
      end
      lsmd_pkg::ST_CLASS: state_next = lsmd_pkg::ST_DONE;
      lsmd_pkg::ST_DONE: begin
        if (res_take) state_next = lsmd_pkg::ST_IDLE;
      end
      default: state_next = lsmd_pkg::ST_IDLE;
    endcase
  end

  // outputs and ALU operand select
  always_comb begin
    in_ready  = (state == lsmd_pkg::ST_IDLE);
    res_valid = (state == lsmd_pkg::ST_DONE);
    alu_a     = acc;
    alu_b     = '0;
    alu_op    = lsmd_pkg::OP_ADD;
    unique case (state)
      lsmd_pkg::ST_SPAN_BASE: begin
        alu_a = {{(lsmd_pkg::ACC_W-lsmd_pkg::DATA_W){1'b0}}, end_q};
        alu_b = lsmd_pkg::SPAN_MOD_ACC;
      end
      lsmd_pkg::ST_SPAN_SUB: begin
        alu_b  = {{(lsmd_pkg::ACC_W-lsmd_pkg::DATA_W){1'b0}}, start_q};
        alu_op = lsmd_pkg::OP_SUB;
      end
      lsmd_pkg::ST_SPAN_WRAP: alu_b = lsmd_pkg::WRAP_RESIDUE;
      lsmd_pkg::ST_SPAN_FIX: begin
        alu_b  = lsmd_pkg::SPAN_MOD_ACC;
        alu_op = acc[lsmd_pkg::ACC_W-1] ? lsmd_pkg::OP_ADD : lsmd_pkg::OP_SUB;
      end
      lsmd_pkg::ST_SPEED: begin
        alu_a = {{(lsmd_pkg::ACC_W-lsmd_pkg::DATA_W){1'b0}}, speed_q};
        alu_b = {{(lsmd_pkg::ACC_W-lsmd_pkg::DATA_W+1){1'b0}},
                 speed_q[lsmd_pkg::DATA_W-1:1]};
      end
      lsmd_pkg::ST_MUL_LIM, lsmd_pkg::ST_MUL_PROD,
      lsmd_pkg::ST_MUL_BASE, lsmd_pkg::ST_MUL_OFS: begin
        alu_b = mcand;
      end
      lsmd_pkg::ST_CMP: begin
        alu_a  = lim;
        alu_b  = acc;
        alu_op = lsmd_pkg::OP_SUB;
      end
      lsmd_pkg::ST_ANG_FIX: begin
        alu_b  = lsmd_pkg::FULL_TURN_ACC;
        alu_op = lsmd_pkg::OP_SUB;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      lsmd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_q   <= command;
          start_q <= packet_start;
          end_q   <= packet_end;
          speed_q <= rotation_speed;
          idx_q   <= point_index;
          rng_q   <= range_mm;
          valid_q <= 1'b0;
        end
      end
      lsmd_pkg::ST_SPAN_BASE, lsmd_pkg::ST_SPAN_SUB, lsmd_pkg::ST_SPAN_WRAP: begin
        acc <= alu_y;
      end
      lsmd_pkg::ST_SPAN_FIX: begin
        if (acc[lsmd_pkg::ACC_W-1] || !alu_cout) acc <= alu_y;
      end
      lsmd_pkg::ST_SPEED: begin
        span   <= acc[lsmd_pkg::DATA_W-1:0];
        mcand  <= alu_y;
        mplier <= lsmd_pkg::ANG_UNIT_MPL;
        acc    <= '0;
      end
      lsmd_pkg::ST_MUL_LIM: begin
        if (!mul_done) begin
          if (mplier[0]) acc <= alu_y;
          mcand  <= {mcand[lsmd_pkg::ACC_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[lsmd_pkg::MPL_W-1:1]};
        end else begin
          lim    <= acc;
          mcand  <= {{(lsmd_pkg::ACC_W-lsmd_pkg::DATA_W){1'b0}}, span};
          mplier <= measure_rate;
          acc    <= '0;
        end
      end
      lsmd_pkg::ST_MUL_PROD, lsmd_pkg::ST_MUL_OFS: begin
        if (!mul_done) begin
          if (mplier[0]) acc <= alu_y;
          mcand  <= {mcand[lsmd_pkg::ACC_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[lsmd_pkg::MPL_W-1:1]};
        end
      end
      lsmd_pkg::ST_CMP: begin
        acc    <= '0;
        mcand  <= {{(lsmd_pkg::ACC_W-lsmd_pkg::DATA_W){1'b0}}, start_q};
        mplier <= lsmd_pkg::POINTS_MPL;
      end
      lsmd_pkg::ST_MUL_BASE: begin
        // start * points first, then index * span accumulates on top
        if (!mul_done) begin
          if (mplier[0]) acc <= alu_y;
          mcand  <= {mcand[lsmd_pkg::ACC_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[lsmd_pkg::MPL_W-1:1]};
        end else begin
          mcand  <= {{(lsmd_pkg::ACC_W-lsmd_pkg::DATA_W){1'b0}}, span};
          mplier <= {{(lsmd_pkg::MPL_W-lsmd_pkg::IDX_W){1'b0}}, idx_q};
        end
      end
      lsmd_pkg::ST_ANG_FIX: begin
        if (!alu_cout) acc <= alu_y;
      end
      lsmd_pkg::ST_CLASS: begin
        valid_q  <= 1'b1;
        sector_q <= lsmd_pkg::classify(acc[lsmd_pkg::ANGLE_W-1:0]);
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  always_comb begin
    res.clear    = (cmd_q == lsmd_pkg::CMD_CLEAR);
    res.valid    = valid_q;
    res.angle    = valid_q ? acc[lsmd_pkg::ANGLE_W-1:0] : '0;
    res.sector   = valid_q ? sector_q : lsmd_pkg::NO_SECTOR;
    res.range_mm = rng_q;
  end

  a_angle_reduced: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.valid) |-> (res.angle < lsmd_pkg::ANGLE_W'(lsmd_pkg::FULL_TURN)))
    else $error("point angle not reduced below a full turn");

  a_clear_not_point: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.clear) |-> !res.valid)
    else $error("clear transaction reported as a valid point");

  a_span_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == lsmd_pkg::ST_SPEED) |-> (acc < lsmd_pkg::SPAN_MOD_ACC))
    else $error("span left unreduced");

  a_invalid_no_sector: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.valid) |-> (res.sector == lsmd_pkg::NO_SECTOR))
    else $error("invalid point carries a sector");

endmodule
`default_nettype wire

[bench/lidar_sector_min_distance_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_sector_min_distance_test
// Self-checking bench for the lidar sector minimum block. Points and clear
// commands go in over valid/ready. Each output transaction is checked field
// by field against a local angle, plausibility and sector-minimum model. The
// run covers several measure_rate settings and a few handshake idle patterns.
// ----------------------------------------------------------------------------
module lidar_sector_min_distance_test;
  import lsmd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles without any transaction
  localparam int TAIL_CYCLES = 60;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] start_ang;
    logic [DATA_W-1:0] end_ang;
    logic [DATA_W-1:0] speed;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] rng;
  } lidar_point_t;

  typedef struct packed {
    logic                   valid;
    logic [OUT_ANGLE_W-1:0] angle;
    logic [SECTOR_W-1:0]    sector;
    logic [3:0][DIST_W-1:0] mins;
  } sector_report_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   command;
  logic [DATA_W-1:0]      packet_start;
  logic [DATA_W-1:0]      packet_end;
  logic [DATA_W-1:0]      rotation_speed;
  logic [IDX_W-1:0]       point_index;
  logic [DATA_W-1:0]      range_mm;
  logic                   out_valid;
  logic                   out_ready;
  logic                   point_valid;
  logic [OUT_ANGLE_W-1:0] point_angle;
  logic [SECTOR_W-1:0]    sector;
  logic [DIST_W-1:0]      nearest_sector_0;
  logic [DIST_W-1:0]      nearest_sector_1;
  logic [DIST_W-1:0]      nearest_sector_2;
  logic [DIST_W-1:0]      nearest_sector_3;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [DATA_W-1:0]      cfg_data;

  // model state
  logic [DIST_W-1:0] sector_min [4];
  logic [DATA_W-1:0] rate_setting;
  sector_report_t    expected_q [$];

  int send_gap_pct;
  int recv_stall_pct;
  int mismatch_count;
  int results_seen;
  int idle_cycles;

  lidar_sector_min_distance dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .packet_start     (packet_start),
    .packet_end       (packet_end),
    .rotation_speed   (rotation_speed),
    .point_index      (point_index),
    .range_mm         (range_mm),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .point_valid      (point_valid),
    .point_angle      (point_angle),
    .sector           (sector),
    .nearest_sector_0 (nearest_sector_0),
    .nearest_sector_1 (nearest_sector_1),
    .nearest_sector_2 (nearest_sector_2),
    .nearest_sector_3 (nearest_sector_3),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // largest span the packet speed allows at the current rate
  function automatic logic [63:0] span_allowance(input logic [DATA_W-1:0] spd);
    if (rate_setting == '0) begin
      return '1;
    end
    return ((64'(spd) + 64'(spd / 2)) * 64'(POINTS_PER_PACKET) * 64'd100)
           / 64'(rate_setting);
  endfunction

  function automatic logic [SECTOR_W-1:0] sector_of_angle(input logic [63:0] a);
    logic [63:0] u;
    u = 64'(ANG_UNIT);
    if (a < 30 * u || a > 330 * u) begin
      return SEC_0;
    end
    if (a > 60 * u && a < 120 * u) begin
      return SEC_1;
    end
    if (a > 150 * u && a < 210 * u) begin
      return SEC_2;
    end
    if (a > 240 * u && a < 300 * u) begin
      return SEC_3;
    end
    return NO_SECTOR;
  endfunction

  // updates the minima and returns the full expected result
  function automatic sector_report_t predict_item(input lidar_point_t p);
    sector_report_t r;
    logic [63:0]    span;
    logic [63:0]    ang;
    int             k;
    r.valid  = 1'b0;
    r.angle  = '0;
    r.sector = NO_SECTOR;
    if (p.cmd == CMD_CLEAR) begin
      for (k = 0; k < 4; k++) sector_min[k] = CLEAR_VALUE;
    end else if (p.speed != '0 && p.idx < POINTS_PER_PACKET && p.rng != '0) begin
      // 64-bit wrap on start > end + 36000 is intended
      span = (64'(p.end_ang) + 64'd36000 - 64'(p.start_ang)) % 64'd36000;
      if (span <= span_allowance(p.speed)) begin
        ang = (64'(p.start_ang) * 64'(POINTS_PER_PACKET) + 64'(p.idx) * span)
              % 64'(FULL_TURN);
        r.valid  = 1'b1;
        r.angle  = ang[OUT_ANGLE_W-1:0];
        r.sector = sector_of_angle(ang);
        if (r.sector != NO_SECTOR && sector_min[r.sector[1:0]] > p.rng) begin
          sector_min[r.sector[1:0]] = p.rng[DIST_W-1:0];
        end
      end
    end
    for (k = 0; k < 4; k++) r.mins[k] = sector_min[k];
    return r;
  endfunction

  function automatic lidar_point_t make_point(input int s_ang, input int e_ang,
                                              input int spd, input int ix,
                                              input int d);
    lidar_point_t p;
    p.cmd       = CMD_POINT;
    p.start_ang = DATA_W'(s_ang);
    p.end_ang   = DATA_W'(e_ang);
    p.speed     = DATA_W'(spd);
    p.idx       = IDX_W'(ix);
    p.rng       = DATA_W'(d);
    return p;
  endfunction

  // mostly plausible packets with random content, some clears and noise
  function automatic lidar_point_t make_random_point();
    lidar_point_t p;
    logic [63:0]  lim;
    logic [63:0]  max_span;
    logic [63:0]  span;
    int           pick;
    pick        = $urandom_range(0, 99);
    p.cmd       = CMD_POINT;
    p.start_ang = DATA_W'($urandom);
    p.end_ang   = DATA_W'($urandom);
    p.speed     = DATA_W'($urandom);
    p.idx       = IDX_W'($urandom);
    p.rng       = DATA_W'($urandom);
    if (pick < 4) begin
      p.cmd = CMD_CLEAR;
    end else if (pick >= 18) begin
      p.speed     = DATA_W'($urandom_range(1, 65535));
      p.start_ang = DATA_W'($urandom_range(0, 35999));
      p.idx       = IDX_W'($urandom_range(0, POINTS_PER_PACKET - 1));
      p.rng       = (pick < 60) ? DATA_W'($urandom_range(1, 32500))
                                : DATA_W'($urandom_range(1, 65535));
      lim      = span_allowance(p.speed);
      max_span = (lim > 64'd35999) ? 64'd35999 : lim;
      span     = 64'($urandom_range(0, int'(max_span)));
      // just past the limit now and then
      if ($urandom_range(0, 9) == 0 && lim < 64'd35999) begin
        span = lim + 64'd1;
      end
      p.end_ang = DATA_W'((64'(p.start_ang) + span) % 64'd36000);
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_point(input lidar_point_t p);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    command        <= p.cmd;
    packet_start   <= p.start_ang;
    packet_end     <= p.end_ang;
    rotation_speed <= p.speed;
    point_index    <= p.idx;
    range_mm       <= p.rng;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_measure_rate(input logic [DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // rate is only written with the block idle
  task automatic change_rate(input logic [DATA_W-1:0] v);
    drain_results();
    repeat (4) @(negedge clk);
    write_measure_rate(v);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // speed 3000 at rate 4500 allows span 1200; zero span puts angle at start*12
  task automatic test_sector_edges();
    send_point(make_point(2999, 2999, 3000, 0, 5000));    // just inside sector 0
    send_point(make_point(3000, 3000, 3000, 0, 100));     // 30 deg edge
    send_point(make_point(4500, 4500, 3000, 0, 100));     // between sectors
    send_point(make_point(6000, 6000, 3000, 0, 100));     // 60 deg edge
    send_point(make_point(6001, 6001, 3000, 0, 3000));
    send_point(make_point(12000, 12000, 3000, 0, 100));   // 120 deg edge
    send_point(make_point(15001, 15001, 3000, 0, 2500));
    send_point(make_point(24001, 24001, 3000, 0, 31999));
    send_point(make_point(30000, 30000, 3000, 0, 100));   // 300 deg edge
    send_point(make_point(33001, 33001, 3000, 0, 7000));  // no update, larger
  endtask

  task automatic test_speed_limit();
    send_point(make_point(35000, 200, 3000, 5, 4000));    // span at limit, wraps
    send_point(make_point(35000, 201, 3000, 5, 10));      // one past limit
    send_point(make_point(1000, 1000, 0, 0, 10));         // stopped rotor
    send_point(make_point(0, 35999, 65535, 11, 10));      // widest span, max speed
  endtask

  task automatic test_index_and_range();
    send_point(make_point(7000, 7300, 3000, 11, 2000));
    send_point(make_point(7000, 7300, 3000, 15, 10));     // index past packet
    send_point(make_point(7000, 7300, 3000, 3, 0));       // no return
    send_point(make_point(18000, 18000, 3000, 0, 65535)); // never a minimum
    send_point(make_point(27000, 27000, 3000, 0, 1));
  endtask

  task automatic test_clear_and_odd_angles();
    lidar_point_t p;
    p     = make_point(65535, 65535, 65535, 15, 65535);
    p.cmd = CMD_CLEAR;
    send_point(p);
    send_point(make_point(65535, 0, 65535, 11, 1234));    // start far past a turn
    send_point(make_point(40000, 50000, 65535, 7, 4321));
    send_point(make_point(0, 0, 65535, 0, 32000));
  endtask

  task automatic test_rate_extremes();
    change_rate(16'd1);
    send_point(make_point(100, 99, 1, 11, 900));
    send_point(make_point(20000, 10000, 65535, 4, 800));
    change_rate(16'hFFFF);
    send_point(make_point(9000, 9000, 1, 2, 700));        // limit is zero
    send_point(make_point(9000, 9001, 1, 2, 600));
    send_point(make_point(9000, 9100, 65535, 6, 500));
    change_rate(16'd0);
    send_point(make_point(1, 0, 1, 11, 400));             // any span passes
    send_point(make_point(33000, 32999, 65535, 10, 300));
    change_rate(RATE_RESET);
  endtask

  task automatic run_random_points(input int count);
    repeat (count) send_point(make_random_point());
  endtask

  task automatic test_random_traffic();
    set_idling(26, 46);
    run_random_points(450);
    set_idling(46, 26);
    change_rate(DATA_W'($urandom_range(500, 20000)));
    run_random_points(450);
    set_idling(0, 0);
    change_rate(DATA_W'($urandom_range(1, 65535)));
    run_random_points(400);
  endtask

  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    sector_report_t         want;
    lidar_point_t           seen;
    logic [3:0][DIST_W-1:0] got_mins;
    logic                   moved;
    int                     k;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", 64'd1, 64'd0);
        end else begin
          want     = expected_q.pop_front();
          got_mins = {nearest_sector_3, nearest_sector_2, nearest_sector_1,
                      nearest_sector_0};
          if (point_valid != want.valid) begin
            report_mismatch("point_valid", 64'(point_valid), 64'(want.valid));
          end
          if (point_angle != want.angle) begin
            report_mismatch("point_angle", 64'(point_angle), 64'(want.angle));
          end
          if (sector != want.sector) begin
            report_mismatch("sector", 64'(sector), 64'(want.sector));
          end
          for (k = 0; k < 4; k++) begin
            if (got_mins[k] != want.mins[k]) begin
              report_mismatch($sformatf("nearest_sector_%0d", k), 64'(got_mins[k]),
                              64'(want.mins[k]));
            end
          end
        end
        results_seen++;
      end
      // output checked first: its expectation is always older than this input
      if (in_valid && in_ready) begin
        moved          = 1'b1;
        seen.cmd       = command;
        seen.start_ang = packet_start;
        seen.end_ang   = packet_end;
        seen.speed     = rotation_speed;
        seen.idx       = point_index;
        seen.rng       = range_mm;
        expected_q.push_back(predict_item(seen));
      end
      if (cfg_valid && cfg_ready) begin
        moved        = 1'b1;
        rate_setting = cfg_data;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = CMD_POINT;
    packet_start   = '0;
    packet_end     = '0;
    rotation_speed = '0;
    point_index    = '0;
    range_mm       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    rate_setting   = RATE_RESET;
    for (int k = 0; k < 4; k++) sector_min[k] = CLEAR_VALUE;
    mismatch_count = 0;
    results_seen   = 0;
    idle_cycles    = 0;
    set_idling(26, 46);
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_sector_edges();
    test_speed_limit();
    test_index_and_range();
    test_clear_and_odd_angles();
    test_rate_extremes();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch("results still outstanding", 64'(expected_q.size()), 64'd0);
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/lsmd_pkg.sv
rtl/core/lsmd_alu.sv
rtl/core/lsmd_ctrl.sv
rtl/core/lidar_sector_min_distance.sv
bench/lidar_sector_min_distance_test.sv
